// ===== hw/rtl/nws_pkg.sv =====
package nws_pkg;

  // Reset value of the decay shift register
  localparam logic [4:0] DECAY_RST = 5'd15;

  localparam int unsigned BIN_W  = 32;
  localparam int unsigned OUT_W  = 48;
  localparam int unsigned FRAC_W = 16;

  typedef struct packed {
    logic [BIN_W-1:0] bin_value;
    logic             is_last;
  } nws_in_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] smoothed_value;
    logic             run_end;
  } nws_out_req_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic shift_in;  // take the accepted bin into the window
    logic clear;     // drop the window count, start a new histogram
    logic acc_clr;   // clear numerator and weight sums
    logic acc_en;    // add one weighted term
    logic div_load;  // load dividend, clear remainder
    logic div_step;  // one restoring division step
    logic push;      // move the quotient into the output register
    logic run_end;   // flag carried with the pushed result
  } nws_cmd_t;

endpackage

// ===== hw/rtl/nws_ctrl.sv =====
module nws_ctrl import nws_pkg::*; #(
  parameter int unsigned HALF_WIDTH = 2,
  localparam int unsigned WinDepth = 2 * HALF_WIDTH,
  localparam int unsigned IdxW     = $clog2(WinDepth),
  localparam int unsigned CntW     = $clog2(WinDepth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_stall_o,
  input  logic [CntW-1:0] cnt_i,
  input  logic            out_free_i,
  output nws_cmd_t        cmd_o,
  output logic [IdxW-1:0] sel_o,
  output logic [IdxW-1:0] gap_o
);

  localparam int unsigned NumW = 64 + IdxW;
  localparam int unsigned DvdW = NumW + FRAC_W;
  localparam int unsigned BitW = $clog2(DvdW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_START,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e          state_q, state_d;
  logic            last_q, last_d;
  logic [IdxW-1:0] oi_q, oi_d;
  logic [IdxW-1:0] o_q, o_d;
  logic [IdxW-1:0] top_q, top_d;
  logic [BitW-1:0] bit_q, bit_d;
  logic [IdxW-1:0] hi_lim;
  logic [IdxW-1:0] cnt_m1;

  assign in_stall_o = (state_q != ST_IDLE);
  assign sel_o      = o_q;
  assign gap_o      = (o_q > oi_q) ? (o_q - oi_q) : (oi_q - o_q);
  assign hi_lim     = oi_q + IdxW'(HALF_WIDTH);
  assign cnt_m1     = IdxW'(cnt_i - CntW'(1));

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    oi_d    = oi_q;
    o_d     = o_q;
    top_d   = top_q;
    bit_d   = bit_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.shift_in = 1'b1;
          last_d         = in_last_i;
          state_d        = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (last_q) begin
          // flush: oldest pending bin first
          oi_d    = (cnt_i < CntW'(HALF_WIDTH)) ? cnt_m1 : IdxW'(HALF_WIDTH - 1);
          state_d = ST_START;
        end else if (cnt_i >= CntW'(HALF_WIDTH)) begin
          oi_d    = IdxW'(HALF_WIDTH - 1);
          state_d = ST_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_START: begin
        cmd_o.acc_clr = 1'b1;
        o_d           = '0;
        top_d         = (hi_lim < cnt_m1) ? hi_lim : cnt_m1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (o_q == top_q) begin
          state_d = ST_LOAD;
        end else begin
          o_d = o_q + IdxW'(1);
        end
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        bit_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (bit_q == BitW'(DvdW - 1)) begin
          state_d = ST_PUSH;
        end else begin
          bit_d = bit_q + BitW'(1);
        end
      end
      ST_PUSH: begin
        if (out_free_i) begin
          cmd_o.push    = 1'b1;
          cmd_o.run_end = last_q && (oi_q == '0);
          if (last_q && (oi_q != '0)) begin
            oi_d    = oi_q - IdxW'(1);
            state_d = ST_START;
          end else begin
            cmd_o.clear = last_q;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
      oi_q    <= '0;
      o_q     <= '0;
      top_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      oi_q    <= oi_d;
      o_q     <= o_d;
      top_q   <= top_d;
      bit_q   <= bit_d;
    end
  end

endmodule

// ===== hw/rtl/nws_dpath.sv =====
module nws_dpath import nws_pkg::*; #(
  parameter int unsigned HALF_WIDTH = 2,
  localparam int unsigned WinDepth = 2 * HALF_WIDTH,
  localparam int unsigned IdxW     = $clog2(WinDepth),
  localparam int unsigned CntW     = $clog2(WinDepth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [4:0]      cfg_wdata_i,
  input  logic [BIN_W-1:0] bin_i,
  input  nws_cmd_t        cmd_i,
  input  logic [IdxW-1:0] sel_i,
  input  logic [IdxW-1:0] gap_i,
  output logic [CntW-1:0] cnt_o,
  output logic            out_free_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output nws_out_req_t    out_req_o
);

  localparam int unsigned NumW = 64 + IdxW;
  localparam int unsigned DenW = 33 + IdxW;
  localparam int unsigned DvdW = NumW + FRAC_W;
  localparam int unsigned ExpW = 5 + IdxW;

  logic [BIN_W-1:0] win_q [WinDepth];
  logic [CntW-1:0]  cnt_q;
  logic [4:0]       decay_q;
  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q;
  logic [DvdW-1:0]  dvd_q;
  logic [DenW-1:0]  rem_q;
  logic [OUT_W-1:0] quo_q;
  logic             out_valid_q;
  nws_out_req_t     out_q;

  logic [ExpW-1:0]  expo;
  logic [63:0]      term;
  logic [32:0]      weight;
  logic [DenW:0]    rem_sh;
  logic             ge;

  // Weight 2^-(shift*d) in Q.32; shifts past the fraction bits fall to zero
  assign expo   = ExpW'(gap_i) * ExpW'(decay_q);
  assign term   = {win_q[sel_i], 32'b0} >> expo;
  assign weight = {1'b1, 32'b0} >> expo;

  assign rem_sh = {rem_q, dvd_q[DvdW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  assign cnt_o       = cnt_q;
  assign out_free_o  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      decay_q     <= DECAY_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        decay_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.shift_in && (cnt_q != CntW'(WinDepth))) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_in) begin
      win_q[0] <= bin_i;
      for (int i = 1; i < WinDepth; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
    if (cmd_i.acc_clr) begin
      num_q <= '0;
      den_q <= '0;
    end else if (cmd_i.acc_en) begin
      num_q <= num_q + NumW'(term);
      den_q <= den_q + DenW'(weight);
    end
    if (cmd_i.div_load) begin
      dvd_q <= {num_q, {FRAC_W{1'b0}}};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= ge ? DenW'(rem_sh - {1'b0, den_q}) : DenW'(rem_sh);
      quo_q <= {quo_q[OUT_W-2:0], ge};
    end
    if (cmd_i.push) begin
      out_q.smoothed_value <= quo_q;
      out_q.run_end        <= cmd_i.run_end;
    end
  end

endmodule

// ===== hw/rtl/normalized_window_smoother.sv =====
// Normalized window smoother: one histogram bin in, smoothed bins out.
// Input channel (in_valid_i / in_stall_o / in_req_i) carries one bin and a
// last-bin flag per request. Output channel (out_valid_o / out_stall_i /
// out_req_o) carries one smoothed Q32.16 value per request; run_end marks
// the result of the final bin. A non-last bin yields one result once
// HALF_WIDTH bins are held; the final bin flushes up to HALF_WIDTH results,
// oldest first, and then the window empties for the next histogram.
// decay_shift is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while idle, the block itself does not enforce this. Timing: one bin is
// worked on at a time. Each result sums the weighted terms in the window, then
// runs the bit-serial restoring divider (one quotient bit per cycle) and waits
// for the output register. A bin with no result frees the input after its
// decide state. The output register lets the next bin enter while the last
// result waits; a stalled receiver holds the result, and the sequencer waits
// before it overwrites it. Reset empties the window, sets decay_shift to 15
// and drops any pending result.
module normalized_window_smoother import nws_pkg::*; #(
  parameter int unsigned HALF_WIDTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  nws_in_req_t  in_req_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output nws_out_req_t out_req_o
);

  localparam int unsigned WinDepth = 2 * HALF_WIDTH;
  localparam int unsigned IdxW     = $clog2(WinDepth);
  localparam int unsigned CntW     = $clog2(WinDepth + 1);

  nws_cmd_t        cmd;
  logic [IdxW-1:0] sel;
  logic [IdxW-1:0] gap;
  logic [CntW-1:0] cnt;
  logic            out_free;

  // Sequencer: walks the window taps, then runs the divider
  nws_ctrl #(
    .HALF_WIDTH(HALF_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_req_i.is_last),
    .in_stall_o (in_stall_o),
    .cnt_i      (cnt),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .sel_o      (sel),
    .gap_o      (gap)
  );

  // Window, weighted sums, divider and output register
  nws_dpath #(
    .HALF_WIDTH(HALF_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bin_i       (in_req_i.bin_value),
    .cmd_i       (cmd),
    .sel_i       (sel),
    .gap_i       (gap),
    .cnt_o       (cnt),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// ===== hw/rtl/nws_checker.sv =====
module nws_checker import nws_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_stall_o,
  input logic         out_valid_o,
  input logic         out_stall_i,
  input nws_out_req_t out_req_o
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_req_o)))
    else $error("stalled result changed or dropped");

  // One bin at a time: stall right after a request is taken
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous bin in work");

  // No result can appear the cycle after a request is taken
  a_no_fast_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Come out of reset with no pending result
  a_rst_out: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind normalized_window_smoother nws_checker u_nws_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nws_pkg::*;

  localparam int unsigned HW          = 2;
  localparam int unsigned WIN         = 2 * HW;
  // Wait after the owed results are out, before a register write and at the end
  // of the run, so that a result still in the divider can finish.
  localparam int unsigned SETTLE      = 128;
  // Longest stretch without any accepted request before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASE_BINS  = 475;

  typedef enum logic {ROW_BIN, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_SMALL, FILL_EXTREME, FILL_FLAT} fill_e;

  // One line of the directed stimulus: either a register write or a bin.
  // Rows with typed set carry their results; other bin rows take theirs from
  // the window predictor.
  typedef struct packed {
    row_kind_e    kind;
    logic [4:0]   shift;
    nws_in_req_t  req;
    logic         typed;
    logic [1:0]   n_res;
    nws_out_req_t res0;
    nws_out_req_t res1;
  } stim_row_t;

  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         cfg_we    = 1'b0;
  logic [4:0]   cfg_wdata = '0;
  logic         bin_valid = 1'b0;
  logic         bin_stall;
  nws_in_req_t  bin_req   = '0;
  logic         res_valid;
  logic         res_stall = 1'b0;
  nws_out_req_t res_req;

  // Idle and stall rates, in percent, for the current phase
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;

  // Predictor state: bins held (newest at entry 0), bin count, decay shift
  logic [31:0]  hist_win [WIN];
  int unsigned  win_cnt = 0;
  logic [4:0]   decay_model = DECAY_RST;

  nws_out_req_t fresh_q [$];  // results of the request just taken
  nws_out_req_t due_q [$];    // results still owed by the block

  int unsigned  mismatches = 0;
  int unsigned  quiet = 0;
  int unsigned  bins_sent = 0;

  stim_row_t    dir_tbl [$];

  normalized_window_smoother #(
    .HALF_WIDTH (HW)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (bin_valid),
    .in_stall_o  (bin_stall),
    .in_req_i    (bin_req),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_req_o   (res_req)
  );

  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  // Weighted mean of the bin held at offset oi while cnt bins are held.
  // Weights are Q.32 powers of two; terms beyond the kept fraction bits
  // still leak into the numerator through the right shift, as the block does.
  function automatic logic [47:0] window_mean(int unsigned oi, int unsigned cnt);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    logic [63:0]  term;
    int unsigned  top;
    int unsigned  o;
    int unsigned  d;
    int unsigned  e;
    num = '0;
    den = '0;
    top = oi + HW;
    if (top > cnt - 1) top = cnt - 1;
    for (o = 0; o <= top; o++) begin
      d = (o > oi) ? o - oi : oi - o;
      e = decay_model * d;
      if (e <= 32) begin
        den  = den + ((128'd1 << 32) >> e);
        term = 64'(hist_win[o]) << (32 - e);
      end else if (e < 64) begin
        term = 64'(hist_win[o]) >> (e - 32);
      end else begin
        term = '0;
      end
      num = num + 128'(term);
    end
    quo = (num << 16) / den;
    return quo[47:0];
  endfunction

  // Shift one bin into the window and collect the results it releases.
  function automatic void take_bin(logic [31:0] v, logic last);
    int unsigned  i;
    int unsigned  k;
    nws_out_req_t r;
    fresh_q.delete();
    for (i = WIN - 1; i > 0; i--) hist_win[i] = hist_win[i-1];
    hist_win[0] = v;
    if (win_cnt < WIN) win_cnt++;
    if (!last) begin
      if (win_cnt >= HW) begin
        r.smoothed_value = window_mean(HW - 1, win_cnt);
        r.run_end        = 1'b0;
        fresh_q = {fresh_q, r};
      end
    end else begin
      // Flush the pending bins, oldest first; the newest one closes the run
      for (k = (win_cnt < HW) ? win_cnt : HW; k > 0; k--) begin
        r.smoothed_value = window_mean(k - 1, win_cnt);
        r.run_end        = (k == 1);
        fresh_q = {fresh_q, r};
      end
      for (i = 0; i < WIN; i++) hist_win[i] = '0;
      win_cnt = 0;
    end
  endfunction

  function automatic stim_row_t cfg_row(logic [4:0] s);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.shift = s;
    return r;
  endfunction

  function automatic stim_row_t bin_row(logic [31:0] v, logic last);
    stim_row_t r;
    r               = '0;
    r.kind          = ROW_BIN;
    r.req.bin_value = v;
    r.req.is_last   = last;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [31:0] v, logic last, logic [1:0] n,
                                          logic [47:0] v0, logic e0,
                                          logic [47:0] v1, logic e1);
    stim_row_t r;
    r       = bin_row(v, last);
    r.typed = 1'b1;
    r.n_res = n;
    r.res0  = '{smoothed_value: v0, run_end: e0};
    r.res1  = '{smoothed_value: v1, run_end: e1};
    return r;
  endfunction

  // Drain the block, let it settle, then write the decay shift.
  task automatic set_decay(logic [4:0] s);
    @(negedge clk);
    bin_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we      <= 1'b0;
    decay_model = s;
  endtask

  // Present one row. A bin request is held until accepted; only then is the
  // predictor advanced and its results (or the typed ones) queued.
  task automatic apply_row(stim_row_t row);
    if (row.kind == ROW_CFG) begin
      set_decay(row.shift);
    end else begin
      @(negedge clk);
      while ($urandom_range(99) < src_idle_pct) begin
        bin_valid <= 1'b0;
        @(negedge clk);
      end
      bin_valid <= 1'b1;
      bin_req   <= row.req;
      @(posedge clk);
      while (bin_stall) @(posedge clk);
      bins_sent++;
      take_bin(row.req.bin_value, row.req.is_last);
      if (row.typed) begin
        if (row.n_res > 0) due_q = {due_q, row.res0};
        if (row.n_res > 1) due_q = {due_q, row.res1};
      end else begin
        foreach (fresh_q[i]) due_q = {due_q, fresh_q[i]};
      end
    end
  endtask

  // Send one histogram of len bins, the last one flagged.
  task automatic run_histogram(int unsigned len, fill_e fill);
    logic [31:0] base;
    logic [31:0] v;
    int unsigned i;
    base = $urandom;
    for (i = 0; i < len; i++) begin
      case (fill)
        FILL_RANDOM: v = $urandom;
        FILL_SMALL:  v = $urandom_range(255);
        FILL_EXTREME: begin
          case ($urandom_range(2))
            0:       v = 32'h0;
            1:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
          endcase
        end
        default:     v = base ^ $urandom_range(15);
      endcase
      apply_row(bin_row(v, i == len - 1));
    end
  endtask

  // Random receiver stall; hold it low through reset
  always @(negedge clk) begin
    res_stall <= rst_n && ($urandom_range(99) < snk_stall_pct);
  end

  // Check each accepted result against the oldest one owed
  always @(posedge clk) begin
    nws_out_req_t want;
    if (rst_n && res_valid && !res_stall) begin
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got value %h run_end %b",
                 $time, res_req.smoothed_value, res_req.run_end);
        mismatches++;
      end else begin
        want = due_q.pop_front();
        if (res_req.smoothed_value !== want.smoothed_value) begin
          $display("%0t: smoothed_value mismatch: expected %h, got %h",
                   $time, want.smoothed_value, res_req.smoothed_value);
          mismatches++;
        end
        if (res_req.run_end !== want.run_end) begin
          $display("%0t: run_end mismatch: expected %b, got %b",
                   $time, want.run_end, res_req.run_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a request
  always @(posedge clk) begin
    if (rst_n) begin
      if ((bin_valid && !bin_stall) || (res_valid && !res_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    logic [4:0]  s;

    for (int unsigned i = 0; i < WIN; i++) hist_win[i] = '0;

    // Directed part. A lone final bin returns itself in Q32.16; a flat
    // histogram at shift 0 returns its own level everywhere.
    dir_tbl = '{
      typed_row(32'd5, 1'b1, 2'd1, 48'h0000_0005_0000, 1'b1, '0, 1'b0),
      typed_row(32'hFFFF_FFFF, 1'b1, 2'd1, 48'hFFFF_FFFF_0000, 1'b1, '0, 1'b0),
      // warm-up: the first bin of a run yields nothing
      typed_row(32'h0, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
      bin_row(32'hFFFF_FFFF, 1'b0),
      bin_row(32'h0, 1'b0),
      bin_row(32'd7, 1'b1),
      cfg_row(5'd0),
      typed_row(32'd100, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
      typed_row(32'd100, 1'b0, 2'd1, 48'h0000_0064_0000, 1'b0, '0, 1'b0),
      typed_row(32'd100, 1'b0, 2'd1, 48'h0000_0064_0000, 1'b0, '0, 1'b0),
      typed_row(32'd100, 1'b1, 2'd2, 48'h0000_0064_0000, 1'b0,
                48'h0000_0064_0000, 1'b1),
      typed_row(32'h0, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
      bin_row(32'd1, 1'b1),
      // large decay: far terms drop out of the weights but leak in shifted
      cfg_row(5'd31),
      typed_row(32'hFFFF_FFFF, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
      bin_row(32'h0, 1'b0),
      bin_row(32'hFFFF_FFFF, 1'b0),
      bin_row(32'h0, 1'b0),
      bin_row(32'hFFFF_FFFF, 1'b1),
      // distance two lands exactly on the last kept fraction bit
      cfg_row(5'd16),
      typed_row(32'd3, 1'b0, 2'd0, '0, 1'b0, '0, 1'b0),
      bin_row(32'hDEAD_BEEF, 1'b0),
      bin_row(32'h0, 1'b0),
      bin_row(32'h0001_0000, 1'b1),
      cfg_row(5'd11),
      bin_row(32'd9, 1'b0),
      bin_row(32'hFFFF_FFFF, 1'b0),
      bin_row(32'd2, 1'b0),
      bin_row(32'd5, 1'b1)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) apply_row(dir_tbl[i]);

    // Random part: four phases of idling and stalling, many short histograms,
    // some long ones to saturate the window, and a new decay shift now and then.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 54; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 54; end
        default: begin src_idle_pct = 30; snk_stall_pct = 30; end
      endcase
      start = bins_sent;
      while (bins_sent - start < PHASE_BINS) begin
        if ($urandom_range(99) < 15) begin
          pick = $urandom_range(5);
          case (pick)
            0:       s = 5'd0;
            1:       s = 5'd31;
            2:       s = 5'd16;
            default: s = $urandom_range(31);
          endcase
          set_decay(s);
        end
        pick = $urandom_range(99);
        if (pick < 30)      len = $urandom_range(4, 1);
        else if (pick < 85) len = $urandom_range(12, 5);
        else                len = $urandom_range(40, 13);
        run_histogram(len, fill_e'($urandom_range(3)));
      end
    end

    // Drop valid, wait for every owed result, then let the block settle
    @(negedge clk);
    bin_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
